@@ rtl/svi_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svi_pkg
// Types and constants shared by the state vector interpolator modules.
// ----------------------------------------------------------------------------
package svi_pkg;

  localparam int TimeW = 49;
  localparam int CompW = 48;
  localparam int NumComp = 6;
  localparam int RowW = 10;
  localparam int CountW = 11;
  localparam int FracW = 32;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic                     mode;
    logic [RowW-1:0]          entry_index;
    logic [TimeW-1:0]         sample_time;
    logic signed [CompW-1:0]  pos_x;
    logic signed [CompW-1:0]  pos_y;
    logic signed [CompW-1:0]  pos_z;
    logic signed [CompW-1:0]  vel_x;
    logic signed [CompW-1:0]  vel_y;
    logic signed [CompW-1:0]  vel_z;
  } in_t;

  typedef struct packed {
    logic                     found;
    logic [RowW-1:0]          upper_row;
    logic signed [CompW-1:0]  out_x;
    logic signed [CompW-1:0]  out_y;
    logic signed [CompW-1:0]  out_z;
    logic signed [CompW-1:0]  out_vx;
    logic signed [CompW-1:0]  out_vy;
    logic signed [CompW-1:0]  out_vz;
  } out_t;

  // One queued word, already classified by the front end.
  typedef struct packed {
    logic is_query;
    logic load_ok;
    in_t  item;
  } cmd_t;

endpackage
`default_nettype wire

@@ rtl/state_vector_interpolator_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// state_vector_interpolator_core
// Table of time-tagged state vectors with linear interpolation queries.
// ----------------------------------------------------------------------------
// A load word writes one table row if its entry index is below MAX_POINTS. A
// query word scans the rows in order, one row per cycle through the time
// memory read port, then runs the restoring divider for the interval
// fraction and interpolates the six components through one shared pair of
// multipliers. The scan covers at most n rows, where n is point_count
// limited to MAX_POINTS; with fewer than two rows in use a query finds no
// interval and skips the scan. A result held by a stalled output keeps the
// next query in S_DONE until the result register is free.
// A two-word queue in front lets input words be taken while a query runs,
// and the result register holds one finished word for the output side.
module state_vector_interpolator_core #(
  parameter int MAX_POINTS = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire svi_pkg::in_t                in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output svi_pkg::out_t                    out_data,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [svi_pkg::CountW-1:0]  cfg_data
);

  logic                       head_valid;
  svi_pkg::cmd_t              head;
  logic                       pop;
  logic [svi_pkg::CountW-1:0] point_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      point_count <= cfg_data;
    end
  end

  svi_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  svi_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .point_count (point_count),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

  // A word that is not found carries all-zero payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.found |-> out_data.upper_row == '0 && out_data.out_x == '0)
    else $error("not-found word has nonzero payload");

  // No result word can appear right after reset.
  assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result word valid right after reset");

  // The queue is only popped when it holds a word.
  assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("queue popped while empty");

endmodule
`default_nettype wire

@@ rtl/svi_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svi_front
// Accepts input words, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module svi_front #(
  parameter int MAX_POINTS = 1024
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire svi_pkg::in_t  in_data,
  output logic               head_valid,
  output svi_pkg::cmd_t      head,
  input  wire logic          pop
);

  svi_pkg::cmd_t slots [2];
  logic [1:0] count;
  logic       rd_ptr;
  logic       wr_ptr;
  logic       push;
  logic       do_pop;
  svi_pkg::cmd_t cmd;

  assign in_ready   = (count != 2'd2);
  assign push       = in_valid && in_ready;
  assign head_valid = (count != 2'd0);
  assign head       = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_comb begin
    cmd          = '0;
    cmd.item     = in_data;
    cmd.is_query = (in_data.mode == svi_pkg::MODE_QUERY);
    cmd.load_ok  = (32'(in_data.entry_index) < MAX_POINTS);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(do_pop);
    end
  end

endmodule
`default_nettype wire

@@ rtl/svi_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svi_back
// Holds the table, scans for the bracketing interval, divides for the
// fraction and interpolates the six components one after another.
// ----------------------------------------------------------------------------
module svi_back #(
  parameter int MAX_POINTS = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [svi_pkg::CountW-1:0]    point_count,
  input  wire logic                          head_valid,
  input  wire svi_pkg::cmd_t                 head,
  output logic                               pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output svi_pkg::out_t                      out_data
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int VW = svi_pkg::CompW * svi_pkg::NumComp;
  localparam int TW = svi_pkg::TimeW;
  localparam int DW = svi_pkg::CompW;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PRIME = 6'b000010,
    S_SCAN  = 6'b000100,
    S_DIV   = 6'b001000,
    S_MUL   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state;

  logic [TW-1:0] time_mem [MAX_POINTS];
  logic [VW-1:0] vec_mem  [MAX_POINTS];

  logic [TW-1:0] tq;
  logic [TW-1:0] tprev;
  logic [TW-1:0] qtime;
  logic [AW-1:0] raddr;
  logic [AW-1:0] row_q;
  logic [AW-1:0] vaddr;
  logic [AW-1:0] hi_row;
  logic [VW-1:0] vq;
  logic [VW-1:0] va;
  logic [VW-1:0] vb;
  logic [VW-1:0] res;
  logic [TW:0]   rem;
  logic [TW:0]   den;
  logic [TW:0]   rem_sh;
  logic [svi_pkg::FracW-1:0] fq;
  logic          zero_f;
  logic          one_f;
  logic [4:0]    dcnt;
  logic [2:0]    comp;
  logic [1:0]    phase;
  logic [DW:0]   mag;
  logic          neg;
  logic [56:0]   pl;
  logic [56:0]   ph;
  logic          found_r;
  logic [CW-1:0] n_eff;
  logic          hit;
  logic          last_row;
  logic          take;
  logic [DW-1:0] comp_a;
  logic [DW-1:0] comp_b;
  logic [DW:0]   diff;
  logic [56:0]   low;
  logic [DW+1:0] m;
  logic [DW-1:0] lerp;

  assign n_eff = (32'(point_count) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(point_count);
  assign pop   = (state == S_IDLE) && head_valid;
  assign hit   = (row_q != '0) && (tprev <= qtime) && (qtime <= tq);
  assign last_row = (32'(row_q) + 1 >= 32'(n_eff));
  assign take  = !out_valid || out_ready;
  assign rem_sh = {rem[TW-1:0], 1'b0};

  assign comp_a = va[32'(comp)*DW +: DW];
  assign comp_b = vb[32'(comp)*DW +: DW];
  assign diff   = {comp_b[DW-1], comp_b} - {comp_a[DW-1], comp_a};
  // Combine the split partial products and round halves of the magnitude up, away from comp_a.
  assign low    = {ph[7:0], 24'd0} + pl;
  assign m      = (DW+2)'(ph >> 8) + (DW+2)'(low >> 32) + (DW+2)'(low[31]);
  assign lerp   = one_f ? comp_b
                : (neg ? comp_a - DW'(m) : comp_a + DW'(m));

  // Table storage with registered reads.
  always_ff @(posedge clk) begin
    if (pop && !head.is_query && head.load_ok) begin
      time_mem[AW'(head.item.entry_index)] <= head.item.sample_time;
      vec_mem[AW'(head.item.entry_index)]  <= {head.item.vel_z, head.item.vel_y,
                                               head.item.vel_x, head.item.pos_z,
                                               head.item.pos_y, head.item.pos_x};
    end
    tq    <= time_mem[raddr];
    row_q <= raddr;
    vq    <= vec_mem[vaddr];
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (pop && head.is_query) begin
          qtime <= head.item.sample_time;
          raddr <= '0;
          res   <= '0;
        end
      end
      S_PRIME: begin
        raddr <= raddr + 1'b1;
      end
      S_SCAN: begin
        raddr <= raddr + 1'b1;
        tprev <= tq;
        if (hit) begin
          hi_row <= row_q;
          vaddr  <= row_q - 1'b1;
          den    <= {1'b0, tq - tprev};
          rem    <= {1'b0, qtime - tprev};
          zero_f <= (tq == tprev);
          one_f  <= (tq != tprev) && (qtime == tq);
          fq     <= '0;
          dcnt   <= '0;
        end
      end
      S_DIV: begin
        dcnt <= dcnt + 1'b1;
        if (dcnt == 5'd0) begin
          vaddr <= hi_row;
        end
        if (dcnt == 5'd1) begin
          va <= vq;
        end
        if (dcnt == 5'd2) begin
          vb <= vq;
        end
        if (rem_sh >= den) begin
          rem <= rem_sh - den;
          fq  <= {fq[svi_pkg::FracW-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          fq  <= {fq[svi_pkg::FracW-2:0], 1'b0};
        end
        if (dcnt == 5'd31) begin
          comp  <= '0;
          phase <= '0;
        end
      end
      S_MUL: begin
        case (phase)
          2'd0: begin
            neg <= diff[DW];
            mag <= diff[DW] ? -diff : diff;
          end
          2'd1: begin
            pl <= 57'(mag[23:0]) * 57'(zero_f ? '0 : fq);
            ph <= 57'(mag[DW:24]) * 57'(zero_f ? '0 : fq);
          end
          default: begin
            res[32'(comp)*DW +: DW] <= lerp;
            comp <= comp + 1'b1;
          end
        endcase
        phase <= (phase == 2'd2) ? 2'd0 : phase + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      found_r   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop && head.is_query) begin
            found_r <= 1'b0;
            state   <= (n_eff < CW'(2)) ? S_DONE : S_PRIME;
          end
        end
        S_PRIME: state <= S_SCAN;
        S_SCAN: begin
          if (hit) begin
            found_r <= 1'b1;
            state   <= S_DIV;
          end else if (last_row) begin
            state <= S_DONE;
          end
        end
        S_DIV: begin
          if (dcnt == 5'd31) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (phase == 2'd2 && comp == 3'(svi_pkg::NumComp - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (take) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && take) begin
      out_data.found     <= found_r;
      out_data.upper_row <= found_r ? svi_pkg::RowW'(hi_row) : '0;
      out_data.out_x     <= found_r ? res[0*DW +: DW] : '0;
      out_data.out_y     <= found_r ? res[1*DW +: DW] : '0;
      out_data.out_z     <= found_r ? res[2*DW +: DW] : '0;
      out_data.out_vx    <= found_r ? res[3*DW +: DW] : '0;
      out_data.out_vy    <= found_r ? res[4*DW +: DW] : '0;
      out_data.out_vz    <= found_r ? res[5*DW +: DW] : '0;
    end
  end

endmodule
`default_nettype wire
